// ===== src/wclk_pkg.sv =====
// Shared types, codes and digit arithmetic for the time-of-day clock.
// Used by wclk_set_conv and wall_clock_hh_mm_ss; depends on nothing else.
`timescale 1ns / 1ps

package wclk_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_RESET = 2'd1,
    ACT_SET   = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  // Time of day held as six decimal digits, HH MM SS.
  typedef struct packed {
    logic [3:0] hour_tens;
    logic [3:0] hour_ones;
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [3:0] sec_tens;
    logic [3:0] sec_ones;
  } hms_t;

  typedef struct packed {
    logic [1:0] quo;
    logic [5:0] rem;
  } div60_t;

  localparam logic [5:0] ASCII_ZERO = 6'd48;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;
  localparam logic [3:0] TENS_MAX   = 4'd5;
  localparam logic [3:0] HOUR_TENS_MAX = 4'd2;
  localparam logic [3:0] HOUR_ONES_LAST = 4'd3;

  // Two decimal digits to binary; each digit is taken at face value (0 to 15).
  function automatic logic [7:0] two_digits(input logic [3:0] tens, input logic [3:0] ones);
    return {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, ones};
  endfunction

  // Split a value of at most 167 into whole minutes (or hours) and a remainder.
  function automatic div60_t div60(input logic [7:0] v);
    div60_t res;
    if (v >= 8'd120) begin
      res.quo = 2'd2;
      res.rem = 6'(v - 8'd120);
    end else if (v >= 8'd60) begin
      res.quo = 2'd1;
      res.rem = 6'(v - 8'd60);
    end else begin
      res.quo = 2'd0;
      res.rem = v[5:0];
    end
    return res;
  endfunction

  // Hours of at most 167 folded into one day.
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] r;
    priority if (v >= 8'd144) r = v - 8'd144;
    else if (v >= 8'd120) r = v - 8'd120;
    else if (v >= 8'd96)  r = v - 8'd96;
    else if (v >= 8'd72)  r = v - 8'd72;
    else if (v >= 8'd48)  r = v - 8'd48;
    else if (v >= 8'd24)  r = v - 8'd24;
    else                  r = v;
    return r[4:0];
  endfunction

  // A value below 60 as two decimal digits, tens in the upper nibble.
  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [3:0] tens;
    logic [5:0] ones;
    priority if (v >= 6'd50) begin
      tens = 4'd5; ones = v - 6'd50;
    end else if (v >= 6'd40) begin
      tens = 4'd4; ones = v - 6'd40;
    end else if (v >= 6'd30) begin
      tens = 4'd3; ones = v - 6'd30;
    end else if (v >= 6'd20) begin
      tens = 4'd2; ones = v - 6'd20;
    end else if (v >= 6'd10) begin
      tens = 4'd1; ones = v - 6'd10;
    end else begin
      tens = 4'd0; ones = v;
    end
    return {tens, ones[3:0]};
  endfunction

endpackage

// ===== src/wclk_set_conv.sv =====
// Converts the six set digits into a normalised time of day.
// Depends on wclk_pkg for the time type and digit arithmetic.
`timescale 1ns / 1ps

module wclk_set_conv
  import wclk_pkg::*;
(
  input  logic [3:0] hour_tens,
  input  logic [3:0] hour_ones,
  input  logic [3:0] min_tens,
  input  logic [3:0] min_ones,
  input  logic [3:0] sec_tens,
  input  logic [3:0] sec_ones,
  output hms_t       time_out
);

  logic [7:0] sec_raw;
  logic [7:0] min_raw;
  logic [7:0] hour_raw;
  div60_t     sec_div;
  div60_t     min_div;
  logic [4:0] hour_norm;
  logic [7:0] sec_bcd;
  logic [7:0] min_bcd;
  logic [7:0] hour_bcd;

  // Excess seconds carry into minutes and excess minutes into hours; the
  // hours then wrap at one day, which is the same as reducing the total.
  always_comb begin
    sec_raw   = two_digits(sec_tens, sec_ones);
    sec_div   = div60(sec_raw);
    min_raw   = two_digits(min_tens, min_ones) + {6'b0, sec_div.quo};
    min_div   = div60(min_raw);
    hour_raw  = two_digits(hour_tens, hour_ones) + {6'b0, min_div.quo};
    hour_norm = mod24(hour_raw);
    sec_bcd   = to_bcd(sec_div.rem);
    min_bcd   = to_bcd(min_div.rem);
    hour_bcd  = to_bcd({1'b0, hour_norm});
    time_out.hour_tens = hour_bcd[7:4];
    time_out.hour_ones = hour_bcd[3:0];
    time_out.min_tens  = min_bcd[7:4];
    time_out.min_ones  = min_bcd[3:0];
    time_out.sec_tens  = sec_bcd[7:4];
    time_out.sec_ones  = sec_bcd[3:0];
  end

endmodule

// ===== src/wall_clock_hh_mm_ss.sv =====
// Top level of the time-of-day clock: input register, time state and result register.
// Depends on wclk_pkg and wclk_set_conv.
`timescale 1ns / 1ps

// The clock keeps the time of day as six decimal digits together with a
// running flag, both cleared by reset. Each input item carries an action: a
// tick advances the time by one second while the clock runs and returns the
// new time; a reset clears the time and leaves the flag alone; a set loads
// the time from six digits (digits above nine, and hours, minutes or seconds
// out of range, simply add their weight, and the total wraps at one day) and,
// if the clock was stopped, starts it and returns the loaded time; a stop
// halts the clock. Ticks while stopped, resets, stops and sets while running
// return nothing. The time is returned as six ASCII digit codes, HH MM SS.
// One item is taken every clock cycle unless an item that returns a result
// waits in the input register for the result register to be free. An item
// sits in the input register while its effect is worked out, and any result
// is loaded into the result register as the item leaves it. The result
// register may hold a finished item while the next one is accepted, and only
// an item that returns a result waits for that register to be free.

module wall_clock_hh_mm_ss
  import wclk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [3:0] in_set_hour_tens,
  input  logic [3:0] in_set_hour_ones,
  input  logic [3:0] in_set_minute_tens,
  input  logic [3:0] in_set_minute_ones,
  input  logic [3:0] in_set_second_tens,
  input  logic [3:0] in_set_second_ones,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_shown_hour_tens,
  output logic [5:0] out_shown_hour_ones,
  output logic [5:0] out_shown_minute_tens,
  output logic [5:0] out_shown_minute_ones,
  output logic [5:0] out_shown_second_tens,
  output logic [5:0] out_shown_second_ones
);

  // Input register.
  logic       in_vld_r;
  action_t    act_r;
  logic [3:0] hour_tens_r;
  logic [3:0] hour_ones_r;
  logic [3:0] min_tens_r;
  logic [3:0] min_ones_r;
  logic [3:0] sec_tens_r;
  logic [3:0] sec_ones_r;

  // Clock state.
  hms_t time_r;
  hms_t time_nxt;
  logic running_r;
  logic running_nxt;

  // Result register.
  logic out_valid_r;
  hms_t shown_r;

  hms_t set_time;
  hms_t tick_time;
  logic makes_result;
  logic out_free;
  logic advance;

  wclk_set_conv u_set_conv (
    .hour_tens (hour_tens_r),
    .hour_ones (hour_ones_r),
    .min_tens  (min_tens_r),
    .min_ones  (min_ones_r),
    .sec_tens  (sec_tens_r),
    .sec_ones  (sec_ones_r),
    .time_out  (set_time)
  );

  // Only a tick while running or a set while stopped produces a result, and
  // only those items need the result register to be free before they retire.
  assign makes_result = ((act_r == ACT_TICK) && running_r) ||
                        ((act_r == ACT_SET) && !running_r);
  assign out_free     = !out_valid_r || out_ready;
  assign advance      = in_vld_r && (!makes_result || out_free);
  assign in_ready     = !in_vld_r || advance;

  // One second later, with carries through the digits and a wrap at midnight.
  // The held time is always normalised, so each digit is compared with its
  // last legal value only.
  always_comb begin
    tick_time = time_r;
    if (time_r.sec_ones != DIGIT_MAX) begin
      tick_time.sec_ones = time_r.sec_ones + 4'd1;
    end else begin
      tick_time.sec_ones = 4'd0;
      if (time_r.sec_tens != TENS_MAX) begin
        tick_time.sec_tens = time_r.sec_tens + 4'd1;
      end else begin
        tick_time.sec_tens = 4'd0;
        if (time_r.min_ones != DIGIT_MAX) begin
          tick_time.min_ones = time_r.min_ones + 4'd1;
        end else begin
          tick_time.min_ones = 4'd0;
          if (time_r.min_tens != TENS_MAX) begin
            tick_time.min_tens = time_r.min_tens + 4'd1;
          end else begin
            tick_time.min_tens = 4'd0;
            if ((time_r.hour_tens == HOUR_TENS_MAX) &&
                (time_r.hour_ones == HOUR_ONES_LAST)) begin
              tick_time.hour_tens = 4'd0;
              tick_time.hour_ones = 4'd0;
            end else if (time_r.hour_ones == DIGIT_MAX) begin
              tick_time.hour_tens = time_r.hour_tens + 4'd1;
              tick_time.hour_ones = 4'd0;
            end else begin
              tick_time.hour_ones = time_r.hour_ones + 4'd1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    time_nxt    = time_r;
    running_nxt = running_r;
    unique case (act_r)
      ACT_TICK: begin
        if (running_r) begin
          time_nxt = tick_time;
        end
      end
      ACT_RESET: begin
        time_nxt = '0;
      end
      ACT_SET: begin
        time_nxt    = set_time;
        running_nxt = 1'b1;
      end
      ACT_STOP: begin
        running_nxt = 1'b0;
      end
      default: begin
        time_nxt    = time_r;
        running_nxt = running_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r       <= action_t'(in_action);
      hour_tens_r <= in_set_hour_tens;
      hour_ones_r <= in_set_hour_ones;
      min_tens_r  <= in_set_minute_tens;
      min_ones_r  <= in_set_minute_ones;
      sec_tens_r  <= in_set_second_tens;
      sec_ones_r  <= in_set_second_ones;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r    <= '0;
      running_r <= 1'b0;
    end else if (advance) begin
      time_r    <= time_nxt;
      running_r <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && makes_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && makes_result) begin
      shown_r <= time_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_shown_hour_tens   = ASCII_ZERO + {2'b00, shown_r.hour_tens};
  assign out_shown_hour_ones   = ASCII_ZERO + {2'b00, shown_r.hour_ones};
  assign out_shown_minute_tens = ASCII_ZERO + {2'b00, shown_r.min_tens};
  assign out_shown_minute_ones = ASCII_ZERO + {2'b00, shown_r.min_ones};
  assign out_shown_second_tens = ASCII_ZERO + {2'b00, shown_r.sec_tens};
  assign out_shown_second_ones = ASCII_ZERO + {2'b00, shown_r.sec_ones};

  // The held time never leaves 00:00:00 to 23:59:59.
  a_time_digits_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (time_r.sec_tens <= TENS_MAX) && (time_r.sec_ones <= DIGIT_MAX) &&
    (time_r.min_tens <= TENS_MAX) && (time_r.min_ones <= DIGIT_MAX))
    else $error("minute or second digit out of range");

  a_hour_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (time_r.hour_tens < HOUR_TENS_MAX) ||
    ((time_r.hour_tens == HOUR_TENS_MAX) && (time_r.hour_ones <= HOUR_ONES_LAST)))
    else $error("hour out of range");

  a_tick_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (act_r == ACT_TICK) && running_r) |=> out_valid_r)
    else $error("tick while running produced no result");

  a_set_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (act_r == ACT_SET)) |=> running_r)
    else $error("set did not leave the clock running");

  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (act_r == ACT_STOP)) |=> !running_r)
    else $error("stop did not halt the clock");

endmodule
